// File: rtl/cti_pkg.sv
// Shared types and constants for the transmit-interval congestion controller.
package cti_pkg;

    // Shared divider sizing
    localparam int DIV_W     = 29;
    localparam int DIV_D_W   = 12;
    localparam int DIV_CNT_W = 5;

    // Register indexes (byte address bit 2)
    localparam logic REG_TARGET = 1'b0;
    localparam logic REG_INIT   = 1'b1;

    // Reset values of the configuration registers
    localparam logic [7:0]  TARGET_RESET = 8'd20;
    localparam logic [11:0] IV_RESET     = 12'd875;

    // Interval limits in ms
    localparam logic [11:0] IV_MAX       = 12'd4000;
    localparam logic [11:0] IV_SLOW      = 12'd1000;
    localparam logic [15:0] IV_MIN       = 16'd150;
    localparam logic [15:0] IV_TRIM_BIG  = 16'd300;
    localparam logic [11:0] IV_SCALE_MIN = 12'd50;
    localparam logic [13:0] JIT_MIN      = 14'd25;

    // Trim steps in ms
    localparam logic [5:0] STEP_FINE   = 6'd3;
    localparam logic [5:0] STEP_NORMAL = 6'd10;
    localparam logic [5:0] STEP_MEDIUM = 6'd20;
    localparam logic [5:0] STEP_COARSE = 6'd50;

    typedef struct packed {
        logic [7:0] seen;
        logic [7:0] own;
        logic [7:0] peers;
    } item_t;

    typedef struct packed {
        logic        radio_reset;
        logic [13:0] jitter;
        logic [15:0] interval;
    } result_t;

    typedef struct packed {
        logic [7:0]  target;
        logic        load_iv;
        logic [11:0] init_iv;
    } cfg_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] nbits;
        logic [DIV_W-1:0]     dividend;
        logic [DIV_D_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

// File: rtl/cti_div.sv
// Shared restoring divider, one quotient bit per cycle, left-aligned dividend.
module cti_div
    import cti_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_D_W:0]     rem_reg;
    logic [DIV_W-1:0]     dq_reg;
    logic [DIV_D_W-1:0]   divisor_reg;

    logic [DIV_D_W:0] rem_sh;
    logic [DIV_D_W:0] diff;
    logic             fits;

    // One restoring step
    assign rem_sh = {rem_reg[DIV_D_W-1:0], dq_reg[DIV_W-1]};
    assign diff   = rem_sh - {1'b0, divisor_reg};
    assign fits   = rem_sh >= {1'b0, divisor_reg};

    // Iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= req.nbits;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Remainder and quotient shift register
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg     <= '0;
            dq_reg      <= req.dividend;
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff : rem_sh;
            dq_reg  <= {dq_reg[DIV_W-2:0], fits};
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = dq_reg;

endmodule

// File: rtl/cti_ctrl.sv
// Sequencer and datapath: rule selection, trim floor, scaling and window state.
module cti_ctrl
    import cti_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     in_valid,
    output logic     in_ready,
    input  item_t    item,
    output logic     res_valid,
    input  logic     res_take,
    output result_t  res,
    output div_req_t div_req,
    input  div_rsp_t div_rsp
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_DIVQ = 3'd2;
    localparam logic [2:0] S_DIVF = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_DIVS = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0]         state_reg, state_next;
    item_t              item_reg, item_next;
    logic signed [17:0] work_reg, work_next;
    logic [DIV_W-1:0]   prod_reg, prod_next;
    logic [15:0]        iv_reg, iv_next;
    logic [1:0]         silent_reg, silent_next;

    logic [8:0]         s;
    logic [13:0]        s14, t14;
    logic               lt95, lt25, lt80, lt50, gt90, gt100, big;
    logic [5:0]         step;
    logic signed [17:0] iv_s, trim_iv;
    logic [12:0]        factor;
    logic [DIV_W-1:0]   prod;
    logic [11:0]        ten_t;
    logic [15:0]        fin_iv;

    function automatic logic signed [17:0] floor_max(input logic signed [17:0] v,
                                                      input logic [11:0] fl);
        logic signed [17:0] f;
        f = $signed({6'b0, fl});
        return (v < f) ? f : v;
    endfunction

    // Load ratio compares against the target
    assign s     = {1'b0, item_reg.seen} + {1'b0, item_reg.own};
    assign s14   = {5'b0, s};
    assign t14   = {6'b0, cfg.target};
    assign lt95  = (s14 * 14'd20) < (t14 * 14'd19);
    assign lt25  = (s14 * 14'd4) < t14;
    assign lt80  = (s14 * 14'd5) < (t14 * 14'd4);
    assign lt50  = (s14 * 14'd2) < t14;
    assign gt90  = (s14 * 14'd10) > (t14 * 14'd9);
    assign gt100 = s14 > t14;
    assign big   = iv_reg > IV_TRIM_BIG;

    // Trim step, the fine step wins
    always_comb
    begin
        step = STEP_NORMAL;
        if (lt80 && big)
            step = STEP_MEDIUM;
        if (lt50 && big)
            step = STEP_COARSE;
        if (gt90)
            step = STEP_FINE;
    end

    assign iv_s    = $signed({2'b0, iv_reg});
    assign trim_iv = (item_reg.own <= item_reg.seen) ? (iv_s - $signed({12'b0, step})) : iv_s;

    // Scaling product and divisor
    assign factor = ({4'b0, s} * 13'd10) + ({5'b0, cfg.target} * 13'd4);
    assign prod   = {13'b0, iv_reg} * {16'b0, factor};
    assign ten_t  = {4'b0, cfg.target} * 12'd10;

    // Final rules
    assign fin_iv = (item_reg.seen == 8'd0) ? {4'b0, IV_SLOW} : work_reg[15:0];
    assign res.jitter      = (fin_iv[15:2] < JIT_MIN) ? JIT_MIN : fin_iv[15:2];
    assign res.interval    = (fin_iv < IV_MIN) ? IV_MIN : fin_iv;
    assign res.radio_reset = (item_reg.seen == 8'd0) && (silent_reg == 2'd3);
    assign res_valid       = state_reg == S_FIN;
    assign in_ready        = state_reg == S_IDLE;

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        work_next   = work_reg;
        prod_next   = prod_reg;
        iv_next     = iv_reg;
        silent_next = silent_reg;
        div_req     = '0;
        if (cfg.load_iv)
            iv_next = {4'b0, cfg.init_iv};
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = item;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                work_next  = iv_s;
                state_next = S_FIN;
                if (cfg.target != 8'd0)
                begin
                    if (lt95)
                    begin
                        if (lt25)
                            work_next = iv_s >>> 1;
                        else if (item_reg.peers == 8'd0)
                            work_next = floor_max(trim_iv, IV_SLOW);
                        else
                        begin
                            work_next        = trim_iv;
                            div_req.start    = 1'b1;
                            div_req.nbits    = DIV_CNT_W'(8);
                            div_req.dividend = {cfg.target, 21'b0};
                            div_req.divisor  = {4'b0, item_reg.peers};
                            state_next       = S_DIVQ;
                        end
                    end
                    else if (gt100)
                    begin
                        prod_next  = prod;
                        state_next = S_MUL;
                    end
                end
            end
            S_DIVQ:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.quotient[7:0] == 8'd0)
                    begin
                        work_next  = floor_max(work_reg, IV_MAX);
                        state_next = S_FIN;
                    end
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.nbits    = DIV_CNT_W'(12);
                        div_req.dividend = {IV_MAX, 17'b0};
                        div_req.divisor  = {4'b0, div_rsp.quotient[7:0]};
                        state_next       = S_DIVF;
                    end
                end
            end
            S_DIVF:
            begin
                if (div_rsp.done)
                begin
                    work_next  = floor_max(work_reg, div_rsp.quotient[11:0]);
                    state_next = S_FIN;
                end
            end
            S_MUL:
            begin
                div_req.start    = 1'b1;
                div_req.nbits    = DIV_CNT_W'(DIV_W);
                div_req.dividend = prod_reg;
                div_req.divisor  = ten_t;
                state_next       = S_DIVS;
            end
            S_DIVS:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.quotient == '0)
                        work_next = $signed({6'b0, IV_SCALE_MIN});
                    else if (div_rsp.quotient > {17'b0, IV_MAX})
                        work_next = $signed({6'b0, IV_MAX});
                    else
                        work_next = $signed({6'b0, div_rsp.quotient[11:0]});
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (res_take)
                begin
                    iv_next = res.interval;
                    if (item_reg.seen != 8'd0 || silent_reg == 2'd3)
                        silent_next = 2'd0;
                    else
                        silent_next = silent_reg + 2'd1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            iv_reg     <= {4'b0, IV_RESET};
            silent_reg <= 2'd0;
        end
        else
        begin
            state_reg  <= state_next;
            iv_reg     <= iv_next;
            silent_reg <= silent_next;
        end
    end

    // Working payload
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        work_reg <= work_next;
        prod_reg <= prod_next;
    end

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && res_take) |=> state_reg == S_IDLE)
        else $error("sequencer did not return to idle after result");

    a_iv_min: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.interval >= IV_MIN)
        else $error("interval below minimum");

    a_reset_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.radio_reset) |-> item_reg.seen == 8'd0)
        else $error("radio reset in a window with traffic");

    a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIVQ || state_reg == S_DIVF || state_reg == S_DIVS))
        else $error("divider result with no waiting state");

endmodule

// File: rtl/congestion_tx_interval_control.sv
// Top level: APB registers, input stream, result register and the sequencer.
//
//  channel   | dir     | handshake          | payload
//  s_*       | in      | s_tvalid/s_tready  | seen_count, own_count, peer_count
//  m_*       | out     | m_tvalid/m_tready  | tx_interval_ms, jitter_ms, radio_reset
//  apb       | in/out  | psel/penable       | target_per_window @0x0, initial_interval @0x4
//
// Per request: the interval is kept, halved or floored at the no-peer value with no
// division; a zero per-peer quotient takes one, the full trim floor two and scaling a
// multiply and one, on the shared restoring divider (one quotient bit per cycle).
// s_tready is high only while the sequencer is idle, so a new request waits until the
// last result leaves it; a stall on m_* holds one result in the output register, one
// in the sequencer. Reset sets the interval to 875 ms, clears the silent-window count.
module congestion_tx_interval_control
    import cti_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // seen_count[7:0], own_count[15:8], peer_count[23:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // tx_interval_ms[15:0], jitter_ms[29:16],
                                   // radio_reset[30], zero[31]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]  target_reg;
    logic [11:0] init_reg;
    logic        out_valid_reg;
    logic [31:0] out_data_reg;

    logic        wr;
    cfg_t        cfg;
    item_t       item;
    result_t     res;
    logic        res_valid;
    logic        slot_free;
    div_req_t    div_req;
    div_rsp_t    div_rsp;

    // Configuration registers
    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= TARGET_RESET;
            init_reg   <= IV_RESET;
        end
        else if (wr)
        begin
            case (paddr[2])
                REG_TARGET: target_reg <= pwdata[7:0];
                REG_INIT:   init_reg   <= pwdata[11:0];
                default:    target_reg <= target_reg;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        case (paddr[2])
            REG_TARGET: prdata = {24'b0, target_reg};
            REG_INIT:   prdata = {20'b0, init_reg};
            default:    prdata = '0;
        endcase
    end

    assign cfg.target  = target_reg;
    assign cfg.load_iv = wr && (paddr[2] == REG_INIT);
    assign cfg.init_iv = pwdata[11:0];

    assign item.seen  = s_tdata[7:0];
    assign item.own   = s_tdata[15:8];
    assign item.peers = s_tdata[23:16];

    cti_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .item      (item),
        .res_valid (res_valid),
        .res_take  (slot_free),
        .res       (res),
        .div_req   (div_req),
        .div_rsp   (div_rsp)
    );

    cti_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Output register
    assign slot_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_valid && slot_free)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && slot_free)
            out_data_reg <= {1'b0, res.radio_reset, res.jitter, res.interval};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
